// ===== src/qmps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmps_pkg
// Shared types and constants for the QR mask penalty score unit.
// ----------------------------------------------------------------------------
package qmps_pkg;
    localparam int unsigned SIZE_W    = 8;
    localparam int unsigned HIST_W    = 10;
    localparam int unsigned RUN_W     = 8;
    localparam int unsigned DARK_W    = 15;
    localparam int unsigned PEN_W     = 22;
    localparam logic [10:0] FINDER_A  = 11'h5D0;
    localparam logic [10:0] FINDER_B  = 11'h05D;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd21;

    typedef logic [PEN_W-1:0] t_penalty;
endpackage
`default_nettype wire

// ===== src/qmps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmps_if
// Valid/ready channel carrying one payload of parameterized width.
// ----------------------------------------------------------------------------
interface qmps_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/qmps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmps_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module qmps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/qr_mask_penalty_score_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qr_mask_penalty_score_unit
// Four-rule QR mask penalty over a row-major stream of modules.
// ----------------------------------------------------------------------------
//  channel   dir  payload            beat
//  s_in      in   module_req [0:0]   one module
//  m_out     out  penalty   [21:0]   one per symbol
//  cfg       in   matrix_size [7:0]  write, no handshake
//
//  Column state is read from RAM as each module is accepted and updated/
//  written back in S_UPD before the next module is taken (one RAM read port
//  sets this). After the last module a restoring divider for the dark ratio
//  runs, then rule 4 is applied in S_R4 before the penalty beat. Reset is
//  synchronous; the column RAMs need no clearing since row 0 writes every
//  entry in use before any value read from them is used.
//  The unit stalls input during the divide and while a penalty beat waits.
// ----------------------------------------------------------------------------
module qr_mask_penalty_score_unit #(
    parameter int unsigned MAX_SIZE = 177
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [7:0]          i_cfg_wdata,
    qmps_if.sink               s_in,
    qmps_if.source             m_out
);
    import qmps_pkg::*;

    localparam int unsigned AW    = $clog2(MAX_SIZE);
    localparam int unsigned TOT_W = 2 * SIZE_W;
    localparam int unsigned NUM_W = DARK_W + 7;
    localparam int unsigned Q_W   = 7;

    typedef enum logic [2:0] {S_IDLE, S_UPD, S_DIV, S_R4, S_OUT} t_state;

    t_state               r_state;
    logic [SIZE_W-1:0]    r_size;
    logic [SIZE_W-1:0]    r_x, r_y;
    logic [RUN_W-1:0]     r_row_run;
    logic [HIST_W-1:0]    r_row_hist;
    logic [HIST_W-1:0]    r_prev_col_hist;   // column x-1 history before update
    logic [DARK_W-1:0]    r_dark;
    t_penalty             r_sum;
    logic                 r_v;
    logic [NUM_W-1:0]     r_rem;
    logic [Q_W-1:0]       r_quo;
    logic [4:0]           r_cnt;
    logic [TOT_W-1:0]     r_total;
    t_penalty             r_pen;

    logic [SIZE_W-1:0]    eff_n;
    logic [RUN_W-1:0]     col_run_q;
    logic [HIST_W-1:0]    col_hist_q;
    logic                 we;
    logic [RUN_W-1:0]     col_run_d;
    logic [HIST_W-1:0]    col_hist_d;
    logic [AW-1:0]        addr;

    always_comb begin
        eff_n = r_size;
        if (r_size == '0) eff_n = 8'd1;
        if ({24'd0, r_size} > 32'(MAX_SIZE)) eff_n = SIZE_W'(MAX_SIZE);
    end

    assign addr = r_x[AW-1:0];

    qmps_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SIZE)) u_run (
        .i_clk(i_clk), .i_we(we), .i_waddr(addr), .i_wdata(col_run_d),
        .i_raddr(addr), .o_rdata(col_run_q));
    qmps_ram #(.WIDTH(HIST_W), .DEPTH(MAX_SIZE)) u_hist (
        .i_clk(i_clk), .i_we(we), .i_waddr(addr), .i_wdata(col_hist_d),
        .i_raddr(addr), .o_rdata(col_hist_q));

    // update-stage combinational logic
    logic [6:0]       add;
    logic [RUN_W-1:0] row_run_d;
    logic             row_same, col_same;
    logic [10:0]      hwin, vwin;

    always_comb begin
        add        = '0;
        row_same   = (r_v == r_row_hist[0]);
        col_same   = (r_v == col_hist_q[0]);
        hwin       = {r_row_hist, r_v};
        vwin       = {col_hist_q, r_v};
        row_run_d  = r_row_run;
        col_run_d  = col_run_q;
        col_hist_d = {col_hist_q[HIST_W-2:0], r_v};
        // up-left neighbor is the newest bit of column x-1 before its update
        if (r_x != '0 && r_y != '0 && row_same && col_same
            && r_v == r_prev_col_hist[0]) add = add + 7'd3;
        if (r_x == '0) begin
            row_run_d = 8'd1;
        end else if (!row_same) begin
            row_run_d = 8'd1;
        end else begin
            if (r_row_run != 8'hFF) row_run_d = r_row_run + 8'd1;
            if (row_run_d == 8'd5) add = add + 7'd3;
            else if (row_run_d > 8'd5) add = add + 7'd1;
        end
        if (r_x >= 8'd10 && (hwin == FINDER_A || hwin == FINDER_B)) add = add + 7'd40;
        if (r_y == '0) begin
            col_run_d  = 8'd1;
            col_hist_d = {{(HIST_W-1){1'b0}}, r_v};
        end else begin
            if (!col_same) begin
                col_run_d = 8'd1;
            end else begin
                if (col_run_q != 8'hFF) col_run_d = col_run_q + 8'd1;
                if (col_run_d == 8'd5) add = add + 7'd3;
                else if (col_run_d > 8'd5) add = add + 7'd1;
            end
            if (r_y >= 8'd10 && (vwin == FINDER_A || vwin == FINDER_B))
                add = add + 7'd40;
        end
    end

    assign we          = (r_state == S_UPD);
    assign s_in.ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.data  = r_pen;

    // rule 4 from quotient p100 = floor(100*dark/total)
    logic [14:0]    q_mul;
    logic [Q_W-1:0] p5, a5, b5, m5;
    always_comb begin
        // divide by 5 through a reciprocal, exact for quotients up to 100
        q_mul = {8'd0, r_quo} * 15'd205;
        p5 = Q_W'(q_mul >> 10);
        a5 = (p5 >= 7'd10) ? p5 - 7'd10 : 7'd10 - p5;
        b5 = (p5 + 7'd1 >= 7'd10) ? p5 + 7'd1 - 7'd10 : 7'd9 - p5;
        m5 = (a5 < b5) ? a5 : b5;
    end

    logic [NUM_W-1:0] num, shin;
    logic [4:0]       bit_sel;
    logic [NUM_W:0]   trial;
    assign num     = {{(NUM_W-DARK_W){1'b0}}, r_dark} * NUM_W'(100);
    assign bit_sel = r_cnt - 5'd1;
    assign shin    = {r_rem[NUM_W-2:0], num[bit_sel]};
    assign trial   = {1'b0, shin} - {{(NUM_W+1-TOT_W){1'b0}}, r_total};

    logic [SIZE_W-1:0] nx, ny;
    always_comb begin
        nx = r_x + 8'd1;
        ny = r_y;
        if (nx >= eff_n) begin
            nx = '0;
            ny = r_y + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_size     <= SIZE_RESET;
            r_x        <= '0;
            r_y        <= '0;
            r_row_run  <= 8'd1;
            r_row_hist <= '0;
            r_dark     <= '0;
            r_sum      <= '0;
        end else if (i_cfg_we) begin
            r_state    <= S_IDLE;
            r_size     <= i_cfg_wdata;
            r_x        <= '0;
            r_y        <= '0;
            r_row_run  <= 8'd1;
            r_row_hist <= '0;
            r_dark     <= '0;
            r_sum      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_v     <= s_in.data[0];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_row_run       <= row_run_d;
                    r_row_hist      <= {r_row_hist[HIST_W-2:0], r_v};
                    r_prev_col_hist <= col_hist_q;
                    r_dark          <= r_dark + DARK_W'(r_v);
                    r_sum           <= r_sum + PEN_W'(add);
                    r_x             <= nx;
                    r_y             <= ny;
                    if (ny >= eff_n) begin
                        r_total <= eff_n * eff_n;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 5'(NUM_W);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    // restoring divide of 100*dark by total, one bit per cycle
                    if (r_cnt == '0) begin
                        r_state <= S_R4;
                    end else begin
                        if (!trial[NUM_W]) begin
                            r_rem <= trial[NUM_W-1:0];
                            r_quo <= {r_quo[Q_W-2:0], 1'b1};
                        end else begin
                            r_rem <= shin;
                            r_quo <= {r_quo[Q_W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_R4: begin
                    r_pen      <= r_sum + PEN_W'(m5 * 7'd10);
                    r_x        <= '0;
                    r_y        <= '0;
                    r_row_run  <= 8'd1;
                    r_row_hist <= '0;
                    r_dark     <= '0;
                    r_sum      <= '0;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (m_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state != S_UPD))
        else $error("update stage repeated");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready && !i_cfg_we) |=> m_out.valid)
        else $error("penalty beat dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPD) |-> !we)
        else $error("stray RAM write");
endmodule
`default_nettype wire

// ===== dv/tb_qr_mask_penalty_score_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qr_mask_penalty_score_unit
// Streams QR symbols of several sizes through the penalty unit and checks
// each penalty beat against a behavioral scorer of all four mask rules.
// ----------------------------------------------------------------------------
module tb_qr_mask_penalty_score_unit;
    import qmps_pkg::*;

    localparam int unsigned MAXN       = 177;
    localparam int unsigned DRAIN_CYC  = 200;
    localparam int unsigned LIMIT_CYC  = 2_000_000;

    // stimulus patterns
    localparam int unsigned PAT_LIGHT  = 0;
    localparam int unsigned PAT_DARK   = 1;
    localparam int unsigned PAT_CHECK  = 2;
    localparam int unsigned PAT_FINDER = 3;
    localparam int unsigned PAT_RANDOM = 4;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [7:0]       i_cfg_wdata;

    qmps_if #(.W(1))     mod_ch ();
    qmps_if #(.W(PEN_W)) pen_ch ();

    qr_mask_penalty_score_unit #(.MAX_SIZE(MAXN)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (mod_ch.sink),
        .m_out       (pen_ch.source)
    );

    // scorer state
    logic [7:0]        size_reg;
    int unsigned       col_idx, row_idx, row_run_len, dark_total;
    logic [9:0]        row_hist;
    int unsigned       col_run_len [MAXN];
    logic [9:0]        col_hist [MAXN];
    logic [PEN_W-1:0]  pen_acc;

    t_penalty    penalty_q[$];
    int unsigned n_errors, n_modules, n_symbols, cyc;
    bit          src_idle_en, snk_idle_en, snk_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned size_eff();
        int unsigned n;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > MAXN) n = MAXN;
        return n;
    endfunction

    function automatic void restart_symbol();
        col_idx = 0; row_idx = 0; row_run_len = 1; row_hist = '0;
        dark_total = 0; pen_acc = '0;
    endfunction

    function automatic int unsigned run_score(ref int unsigned run, input bit same);
        if (!same) begin
            run = 1;
            return 0;
        end
        if (run < 255) run++;
        if (run == 5) return 3;
        if (run > 5) return 1;
        return 0;
    endfunction

    function automatic int unsigned finder_score(logic [9:0] h, bit v);
        logic [10:0] w;
        w = {h, v};
        return (w == FINDER_A || w == FINDER_B) ? 40 : 0;
    endfunction

    function automatic int unsigned dist50(int unsigned a);
        return a >= 50 ? a - 50 : 50 - a;
    endfunction

    // advance the scorer by one module; push the penalty at symbol end
    function automatic void score_module(bit v);
        int unsigned n, x, y, add, tot, lo, a, b;
        n = size_eff(); x = col_idx; y = row_idx; add = 0;
        if (x >= n) x = 0;
        if (y >= n) y = 0;
        if (x > 0 && y > 0)
            if (v == row_hist[0] && v == col_hist[x][0] && v == col_hist[x-1][1])
                add += 3;
        if (x > 0) add += run_score(row_run_len, v == row_hist[0]);
        else row_run_len = 1;
        if (x >= 10) add += finder_score(row_hist, v);
        row_hist = {row_hist[8:0], v};
        if (y > 0) begin
            add += run_score(col_run_len[x], v == col_hist[x][0]);
            if (y >= 10) add += finder_score(col_hist[x], v);
            col_hist[x] = {col_hist[x][8:0], v};
        end else begin
            col_run_len[x] = 1;
            col_hist[x] = {9'b0, v};
        end
        dark_total = (dark_total + v) & 16'h7FFF;
        pen_acc = PEN_W'(pen_acc + add);
        x++;
        if (x >= n) begin
            x = 0;
            y++;
        end
        col_idx = x; row_idx = y;
        if (y >= n) begin
            tot = n * n;
            lo = ((dark_total * 100) / tot / 5) * 5;
            a = dist50(lo) / 5;
            b = dist50(lo + 5) / 5;
            penalty_q.push_back(t_penalty'(pen_acc + (a < b ? a : b) * 10));
            n_symbols++;
            restart_symbol();
        end
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && pen_ch.valid && pen_ch.ready) begin
            if (penalty_q.size() == 0) begin
                $error("penalty beat with none expected: %0d", pen_ch.data);
                n_errors++;
            end else begin
                t_penalty exp_pen;
                exp_pen = penalty_q.pop_front();
                if (pen_ch.data !== exp_pen) begin
                    $error("penalty: expected %0d actual %0d", exp_pen, pen_ch.data);
                    n_errors++;
                end
            end
        end
    end

    initial begin : sink_proc
        int unsigned k;
        pen_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (snk_hold) begin
                pen_ch.ready <= 1'b0;
                k = 0;
                while (k < 3000) begin
                    @(posedge i_clk);
                    k++;
                end
                snk_hold = 0;
            end else if (snk_idle_en && $urandom_range(0, 9) == 0) begin
                pen_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            pen_ch.ready <= 1'b1;
        end
    end

    task automatic send_module(bit v);
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            mod_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        mod_ch.valid <= 1'b1;
        mod_ch.data  <= v;
        @(posedge i_clk iff mod_ch.ready);
        score_module(v);
        n_modules++;
        // drop valid for the update cycle, in which the unit is busy anyway
        mod_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (penalty_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_size(logic [7:0] s);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_reg = s;
        restart_symbol();
    endtask

    task automatic send_symbols(int unsigned cnt, int unsigned mode);
        int unsigned n;
        n = size_eff();
        repeat (cnt) begin
            for (int unsigned i = 0; i < n * n; i++) begin
                case (mode)
                    PAT_LIGHT:  send_module(1'b0);
                    PAT_DARK:   send_module(1'b1);
                    PAT_CHECK:  send_module(1'(((i % n) ^ (i / n)) & 1));
                    PAT_FINDER: send_module(1'(FINDER_A >> (10 - (i % n) % 11)));
                    default:    send_module(1'($urandom_range(0, 1)));
                endcase
            end
        end
    endtask

    task automatic test_directed();
        send_send_wrap:
        begin
            send_symbols(1, PAT_DARK);   // all dark at reset size
        end
        write_size(8'd1);
        send_module(1'b1); send_module(1'b0); send_module(1'b1);
        write_size(8'd0);
        send_module(1'b0); send_module(1'b1);
    endtask

    task automatic test_patterns();
        write_size(8'd2);
        for (int unsigned i = 0; i < 16; i++) send_module(i[0] ^ i[2]);
        write_size(8'd11);
        send_symbols(1, PAT_FINDER);     // finder-like rows
        write_size(8'd6);
        send_symbols(1, PAT_CHECK);      // checkerboard
    endtask

    task automatic test_restart();
        write_size(8'd5);
        repeat (7) send_module(1'($urandom_range(0, 1)));
        // mid-symbol write restarts the symbol
        i_cfg_we <= 1'b1; i_cfg_wdata <= 8'd3;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = 8'd3; restart_symbol();
        send_symbols(2, PAT_RANDOM);
    endtask

    task automatic test_large_sizes();
        write_size(8'd255);              // saturates to the maximum
        // full first row touches every column entry, then a few of row 1
        for (int unsigned i = 0; i < 180; i++) send_module(1'($urandom_range(0, 1)));
    endtask

    task automatic test_random();
        int unsigned cnt;
        src_idle_en = 1; snk_idle_en = 1;
        cnt = 0;
        while (cnt < 60) begin
            write_size(8'($urandom_range(2, 6)));
            send_symbols($urandom_range(1, 3), $urandom_range(0, 9) < 8 ? PAT_RANDOM
                         : $urandom_range(PAT_LIGHT, PAT_FINDER));
            cnt += size_eff() * size_eff();
        end
    endtask

    task automatic test_backpressure();
        write_size(8'd2);
        fork
            snk_hold = 1;
            send_symbols(6, PAT_RANDOM);
        join
    endtask

    task automatic test_no_idle();
        src_idle_en = 0; snk_idle_en = 0;
        write_size(8'd4);
        send_symbols(4, PAT_RANDOM);
    endtask

    initial begin
        cyc = 0; n_errors = 0; n_modules = 0; n_symbols = 0;
        src_idle_en = 0; snk_idle_en = 0; snk_hold = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        mod_ch.valid = 1'b0; mod_ch.data = '0;
        size_reg = SIZE_RESET;
        restart_symbol();
        for (int i = 0; i < MAXN; i++) begin
            col_run_len[i] = 0;
            col_hist[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_patterns();
        test_restart();
        src_idle_en = 1; snk_idle_en = 1;
        test_large_sizes();
        test_backpressure();
        test_random();
        test_no_idle();
        wait_drained();
        $display("covered %0d modules in %0d symbols, sizes 0..255, with stalls",
                 n_modules, n_symbols);
        if (n_errors == 0 && penalty_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== files.f =====
src/qmps_pkg.sv
src/qmps_if.sv
src/qmps_ram.sv
src/qr_mask_penalty_score_unit.sv
dv/tb_qr_mask_penalty_score_unit.sv
